// ===== src/igc_pkg.sv =====
// Shared constants, types and the divider step function for the iteration gradient colorizer.
// No dependencies; imported by every module of the block.
package igc_pkg;

	localparam int SEGMENTS        = 4;
	localparam int FRACTION_BITS   = 8;
	localparam int COUNT_WIDTH     = 16;

	localparam int SEG_BITS        = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
	localparam int POS_WIDTH       = SEG_BITS + FRACTION_BITS;
	localparam int PROD_WIDTH      = COUNT_WIDTH + SEG_BITS;
	localparam int LIMIT_W         = 16;
	localparam int CMP_W           = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;
	localparam int STEPS_PER_STAGE = 2;
	localparam int DIV_STAGES      = (POS_WIDTH + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

	localparam int CHAN_W          = 8;
	localparam int COLOR_W         = 3 * CHAN_W;
	localparam int PAL_REGS        = 5;
	localparam int PAL_IDX_W       = $clog2(SEGMENTS + 1);
	localparam int MIX_W           = FRACTION_BITS + CHAN_W + 1;

	localparam int CFG_REGS        = PAL_REGS + 1;
	localparam int CFG_IDX_W       = $clog2(CFG_REGS);
	localparam int CFG_DATA_W      = COLOR_W;

	localparam int S_DATA_W        = ((COUNT_WIDTH + 7) / 8) * 8;
	localparam int M_DATA_W        = COLOR_W;

	// register map
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = CFG_IDX_W'(0);
	localparam int                   REG_PAL_BASE = 1;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(256);

	typedef logic [COLOR_W-1:0] color_t;
	typedef color_t pal_t [PAL_REGS];

	localparam pal_t PAL_RESET = '{24'h000764, 24'h206BCB, 24'hEDFFFF, 24'hFFAA00, 24'h000200};

	// red in the lowest bits of the output beat
	typedef struct packed {
		logic [CHAN_W-1:0] blue;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] red;
	} rgb_t;

	// partial remainder, plus dividend bits still to bring down that are
	// replaced from the bottom by quotient bits
	typedef struct packed {
		logic [LIMIT_W-1:0]   rem;
		logic [POS_WIDTH-1:0] qd;
	} div_state_t;

	// one restoring division step
	function automatic div_state_t div_step(input div_state_t st, input logic [LIMIT_W-1:0] lim);
		logic [LIMIT_W:0] trial;
		logic             qbit;
		div_state_t       res;
		trial = {st.rem, st.qd[POS_WIDTH-1]};
		qbit  = (trial >= {1'b0, lim});
		if (qbit) begin
			trial = trial - {1'b0, lim};
		end
		res.rem = trial[LIMIT_W-1:0];
		res.qd  = {st.qd[POS_WIDTH-2:0], qbit};
		return res;
	endfunction

endpackage

// ===== src/igc_cfg.sv =====
// Configuration register file: iteration limit and the five palette colors.
// Depends on igc_pkg.
module igc_cfg import igc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  index,
	input  logic [CFG_DATA_W-1:0] wdata,
	output logic [LIMIT_W-1:0]    max_iter,
	output pal_t                  pal
);

	logic [LIMIT_W-1:0] max_iter_q;
	pal_t               pal_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_iter_q <= LIMIT_RESET;
			pal_q      <= PAL_RESET;
		end else if (wr_en) begin
			if (index == REG_MAX_ITER) begin
				max_iter_q <= wdata[LIMIT_W-1:0];
			end
			for (int i = 0; i < PAL_REGS; i++) begin
				if (index == CFG_IDX_W'(REG_PAL_BASE + i)) begin
					pal_q[i] <= wdata[COLOR_W-1:0];
				end
			end
		end
	end

	assign max_iter = max_iter_q;
	assign pal      = pal_q;

endmodule

// ===== src/igc_div.sv =====
// Count wrap, scaling and pipelined restoring divider producing the gradient position.
// Depends on igc_pkg.
module igc_div import igc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   adv,
	input  logic                   in_valid,
	input  logic [COUNT_WIDTH-1:0] in_count,
	input  logic [LIMIT_W-1:0]     lim,
	output logic                   out_valid,
	output logic [POS_WIDTH-1:0]   out_pos
);

	logic       v_s  [DIV_STAGES+1];
	div_state_t st_s [DIV_STAGES+1];

	logic [COUNT_WIDTH-1:0] count_c;
	logic [PROD_WIDTH-1:0]  scaled_c;
	div_state_t             prep_c;
	div_state_t             next_c [DIV_STAGES];

	// counts at or above the limit wrap to zero; high part of the scaled
	// count is already below the limit, so it seeds the remainder
	always_comb begin
		count_c     = (CMP_W'(in_count) >= CMP_W'(lim)) ? '0 : in_count;
		scaled_c    = PROD_WIDTH'(PROD_WIDTH'(count_c) * PROD_WIDTH'(SEGMENTS));
		prep_c.rem  = LIMIT_W'(scaled_c[PROD_WIDTH-1:SEG_BITS]);
		prep_c.qd   = {scaled_c[SEG_BITS-1:0], {FRACTION_BITS{1'b0}}};
	end

	always_comb begin
		for (int i = 0; i < DIV_STAGES; i++) begin
			next_c[i] = st_s[i];
			for (int j = 0; j < STEPS_PER_STAGE; j++) begin
				if (i * STEPS_PER_STAGE + j < POS_WIDTH) begin
					next_c[i] = div_step(next_c[i], lim);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= DIV_STAGES; i++) begin
				v_s[i] <= 1'b0;
			end
		end else if (adv) begin
			v_s[0] <= in_valid;
			for (int i = 0; i < DIV_STAGES; i++) begin
				v_s[i+1] <= v_s[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s[0] <= prep_c;
			for (int i = 0; i < DIV_STAGES; i++) begin
				st_s[i+1] <= next_c[i];
			end
		end
	end

	assign out_valid = v_s[DIV_STAGES];
	assign out_pos   = st_s[DIV_STAGES].qd;

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(v_s[DIV_STAGES]) && $stable(v_s[0]))
		else $error("divider valid moved while stalled");

	a_entry: assert property (@(posedge clk) disable iff (!arst_n)
		adv && in_valid |=> v_s[0])
		else $error("accepted beat did not enter the divider");

endmodule

// ===== src/igc_blend.sv =====
// Palette segment select and per-channel linear blend, with the output register.
// Depends on igc_pkg.
module igc_blend import igc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic                 in_valid,
	input  logic [POS_WIDTH-1:0] in_pos,
	input  pal_t                 pal,
	output logic                 out_valid,
	output rgb_t                 out_rgb
);

	function automatic color_t pal_read(input pal_t p, input logic [PAL_IDX_W-1:0] idx);
		color_t c;
		c = '0;
		for (int i = 0; i < PAL_REGS; i++) begin
			if (int'(idx) == i) begin
				c = p[i];
			end
		end
		return c;
	endfunction

	logic [SEG_BITS-1:0]      k_raw_c;
	logic [PAL_IDX_W-1:0]     lo_idx_c;
	logic [PAL_IDX_W-1:0]     hi_idx_c;
	logic [FRACTION_BITS-1:0] f_c;
	logic [FRACTION_BITS:0]   inv_f_c;
	color_t                   lo_c;
	color_t                   hi_c;

	logic                     v_s7;
	logic [MIX_W-1:0]         lo_p_s7 [3];
	logic [MIX_W-2:0]         hi_p_s7 [3];
	logic [MIX_W-1:0]         sum_c   [3];

	logic                     v_s8;
	logic [CHAN_W-1:0]        chan_s8 [3];

	always_comb begin
		k_raw_c = in_pos[POS_WIDTH-1:FRACTION_BITS];
		if (int'(k_raw_c) > SEGMENTS - 1) begin
			lo_idx_c = PAL_IDX_W'(SEGMENTS - 1);
		end else begin
			lo_idx_c = PAL_IDX_W'(k_raw_c);
		end
		hi_idx_c = lo_idx_c + PAL_IDX_W'(1);
		f_c      = in_pos[FRACTION_BITS-1:0];
		inv_f_c  = {1'b1, {FRACTION_BITS{1'b0}}} - {1'b0, f_c};
		lo_c     = pal_read(pal, lo_idx_c);
		hi_c     = pal_read(pal, hi_idx_c);
	end

	// channel 0 is blue (low byte of a palette color), channel 2 is red
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			sum_c[ch] = lo_p_s7[ch] + MIX_W'(hi_p_s7[ch]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (adv) begin
			v_s7 <= in_valid;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int ch = 0; ch < 3; ch++) begin
				lo_p_s7[ch] <= MIX_W'(inv_f_c) * MIX_W'(lo_c[ch*CHAN_W +: CHAN_W]);
				hi_p_s7[ch] <= (MIX_W-1)'(f_c) * (MIX_W-1)'(hi_c[ch*CHAN_W +: CHAN_W]);
				chan_s8[ch] <= sum_c[ch][FRACTION_BITS +: CHAN_W];
			end
		end
	end

	assign out_valid     = v_s8;
	assign out_rgb.red   = chan_s8[2];
	assign out_rgb.green = chan_s8[1];
	assign out_rgb.blue  = chan_s8[0];

	// weights add up to one, so the blend never reaches the top bit
	a_blend_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s7 |-> !sum_c[0][MIX_W-1] && !sum_c[1][MIX_W-1] && !sum_c[2][MIX_W-1])
		else $error("blend sum out of range");

endmodule

// ===== src/iteration_gradient_colorizer.sv =====
// Top level of the iteration gradient colorizer: config registers, divider and blend.
// Depends on igc_pkg, igc_cfg, igc_div and igc_blend.
//
// Usage: each beat on the s_ side carries one escape-iteration count in
// s_tdata; each beat on the m_ side carries one pixel, red in the low byte,
// then green, then blue. Every input beat gives exactly one output beat, in
// order. The cfg port writes the iteration limit (index 0) and the five
// palette colors (indexes 1 to 5); write it only while the pipeline is empty.
// An accepted input beat reaches m_tvalid through one stage for the limit
// wrap and scaling, five divider stages doing two quotient bits each, one
// multiply stage and the output register. Unless m_tready stalls, the
// fully pipelined divider and blend multipliers take one beat per clock.
// Reset clears all valid bits and loads the default limit of 256 and the
// default palette. While m_tvalid is high and m_tready low, the whole
// pipeline holds and s_tready drops; nothing is lost or repeated.
module iteration_gradient_colorizer import igc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_DATA_W-1:0]   s_tdata,   // [15:0] iteration_count
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_DATA_W-1:0]   m_tdata,   // [7:0] red, [15:8] green, [23:16] blue
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	logic                 adv;
	logic [LIMIT_W-1:0]   max_iter;
	logic [LIMIT_W-1:0]   lim_c;
	pal_t                 pal;
	logic                 div_valid;
	logic [POS_WIDTH-1:0] div_pos;
	rgb_t                 rgb;

	// advance the whole pipe unless a finished pixel is waiting
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	// a zero limit behaves as one
	assign lim_c = (max_iter == '0) ? LIMIT_W'(1) : max_iter;

	igc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_wr_en),
		.index    (cfg_index),
		.wdata    (cfg_wdata),
		.max_iter (max_iter),
		.pal      (pal)
	);

	igc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (s_tvalid),
		.in_count  (s_tdata[COUNT_WIDTH-1:0]),
		.lim       (lim_c),
		.out_valid (div_valid),
		.out_pos   (div_pos)
	);

	igc_blend u_blend (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (div_valid),
		.in_pos    (div_pos),
		.pal       (pal),
		.out_valid (m_tvalid),
		.out_rgb   (rgb)
	);

	assign m_tdata = rgb;

endmodule

// ===== verif/iteration_gradient_colorizer_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for iteration_gradient_colorizer: stream stimulus, config writes
// and a scoreboard that predicts each pixel. Depends on igc_pkg and the block's RTL.
module iteration_gradient_colorizer_tb;
	import igc_pkg::*;

	// Mirror of the config registers and the queue of pixels still owed by the block.
	class pixel_scoreboard;
		logic [15:0] limit_reg;
		color_t      palette [PAL_REGS];
		rgb_t        owed_pixels [$];
		int          failures;

		function new();
			limit_reg  = 16'd256;
			palette[0] = 24'h000764;
			palette[1] = 24'h206BCB;
			palette[2] = 24'hEDFFFF;
			palette[3] = 24'hFFAA00;
			palette[4] = 24'h000200;
			failures   = 0;
		endfunction

		function void write_reg(int idx, logic [23:0] val);
			if (idx == int'(REG_MAX_ITER)) begin
				limit_reg = val[15:0];
			end else if (idx >= REG_PAL_BASE && idx < REG_PAL_BASE + PAL_REGS) begin
				palette[idx - REG_PAL_BASE] = val;
			end
		endfunction

		function logic [7:0] mix_channel(logic [7:0] lo, logic [7:0] hi, int frac);
			int sum;
			sum = (256 - frac) * int'(lo) + frac * int'(hi);
			return 8'(sum >> 8);
		endfunction

		function rgb_t gradient_pixel(logic [15:0] count);
			int     lim;
			int     c;
			int     pos;
			int     seg;
			int     frac;
			color_t lo;
			color_t hi;
			rgb_t   px;
			lim = (limit_reg == 16'd0) ? 1 : int'(limit_reg);
			c   = (int'(count) >= lim) ? 0 : int'(count);
			pos = (c << 10) / lim;
			seg = pos >> 8;
			if (seg > 3) begin
				seg = 3;
			end
			frac     = pos & 255;
			lo       = palette[seg];
			hi       = palette[seg + 1];
			px.red   = mix_channel(lo[23:16], hi[23:16], frac);
			px.green = mix_channel(lo[15:8], hi[15:8], frac);
			px.blue  = mix_channel(lo[7:0], hi[7:0], frac);
			return px;
		endfunction

		function void note_count(logic [15:0] count);
			owed_pixels.push_back(gradient_pixel(count));
		endfunction

		function void check_pixel(logic [M_DATA_W-1:0] beat);
			rgb_t got;
			rgb_t want;
			got = rgb_t'(beat);
			if (owed_pixels.size() == 0) begin
				$error("pixel beat with none owed: %h", beat);
				failures++;
				return;
			end
			want = owed_pixels.pop_front();
			if (got.red !== want.red) begin
				$error("red mismatch: expected %0d, actual %0d", want.red, got.red);
				failures++;
			end
			if (got.green !== want.green) begin
				$error("green mismatch: expected %0d, actual %0d", want.green, got.green);
				failures++;
			end
			if (got.blue !== want.blue) begin
				$error("blue mismatch: expected %0d, actual %0d", want.blue, got.blue);
				failures++;
			end
		endfunction

		function int pending();
			return owed_pixels.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_DATA_W-1:0]   s_tdata;   // [15:0] iteration_count
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_DATA_W-1:0]   m_tdata;   // [7:0] red, [15:8] green, [23:16] blue
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	pixel_scoreboard sb = new();
	bit              calm;
	int              idle_pct;

	iteration_gradient_colorizer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				sb.note_count(s_tdata[15:0]);
			end
			if (m_tvalid && m_tready) begin
				sb.check_pixel(m_tdata);
			end
		end
	end

	// Output side: random ready bursts and stalls, always ready once calm.
	initial begin
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (calm) begin
				m_tready <= 1'b1;
				@(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 30)) @(posedge clk);
				if (!calm) begin
					m_tready <= 1'b0;
					for (int n = $urandom_range(1, 15); n > 0 && !calm; n--) begin
						@(posedge clk);
					end
				end
			end
		end
	end

	// Drive one register; the write lands at the next edge.
	task automatic write_reg(int idx, logic [23:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_IDX_W'(idx);
		cfg_wdata <= val;
		sb.write_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic end_writes();
		cfg_wr_en <= 1'b0;
		cfg_wdata <= CFG_DATA_W'($urandom);
		@(posedge clk);
	endtask

	task automatic send_count(logic [15:0] count);
		if (!calm && idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			s_tdata  <= S_DATA_W'($urandom);
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= S_DATA_W'(count);
		do @(posedge clk); while (!s_tready);
	endtask

	// Stop sending and hold until every owed pixel is out and the pipeline is empty.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_palette(logic [23:0] c0, logic [23:0] c1, logic [23:0] c2,
			logic [23:0] c3, logic [23:0] c4);
		write_reg(REG_PAL_BASE, c0);
		write_reg(REG_PAL_BASE + 1, c1);
		write_reg(REG_PAL_BASE + 2, c2);
		write_reg(REG_PAL_BASE + 3, c3);
		write_reg(REG_PAL_BASE + 4, c4);
	endtask

	function automatic logic [23:0] pick_color();
		case ($urandom_range(5))
			0:       return 24'h000000;
			1:       return 24'hFFFFFF;
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_limit();
		case ($urandom_range(7))
			0:       return 16'd0;
			1:       return 16'd1;
			2:       return 16'($urandom_range(2, 8));
			3:       return 16'($urandom_range(9, 1024));
			4:       return 16'hFFFF;
			default: return 16'($urandom_range(1, 65535));
		endcase
	endfunction

	function automatic logic [15:0] pick_count(int lim);
		int r;
		r = $urandom_range(9);
		if (r < 6) begin
			return (lim > 1) ? 16'($urandom_range(0, lim - 1)) : 16'd0;
		end else if (r == 6) begin
			return 16'(lim - 1 + int'($urandom_range(2)));
		end else if (r == 7) begin
			return ($urandom_range(1) == 0) ? 16'd0 : 16'hFFFF;
		end
		return 16'($urandom_range(0, 65535));
	endfunction

	initial begin
		logic [15:0] lim;
		int          eff_lim;

		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		m_tready  <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		calm      = 1'b0;
		idle_pct  = 30;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// Reset palette and limit 256: segment boundaries and the at-limit wrap.
		send_count(16'd0);
		send_count(16'd1);
		send_count(16'd63);
		send_count(16'd64);
		send_count(16'd127);
		send_count(16'd128);
		send_count(16'd191);
		send_count(16'd192);
		send_count(16'd255);
		send_count(16'd256);
		send_count(16'hFFFF);
		drain();

		// Full limit, extreme colors; unmapped indexes must leave the registers alone.
		write_reg(REG_MAX_ITER, {8'hA5, 16'hFFFF});
		write_palette(24'h000000, 24'hFFFFFF, 24'hAA55AA, 24'hFFFFFF, 24'h000000);
		for (int idx = CFG_REGS; idx < (1 << CFG_IDX_W); idx++) begin
			write_reg(idx, 24'($urandom));
		end
		end_writes();
		send_count(16'hFFFE);
		send_count(16'd16383);
		send_count(16'd16384);
		send_count(16'd49152);
		send_count(16'd32767);
		send_count(16'hFFFF);
		drain();

		// Zero limit behaves as one: everything lands on the first color.
		write_reg(REG_MAX_ITER, 24'h5A0000);
		end_writes();
		send_count(16'd0);
		send_count(16'hFFFF);
		send_count(16'd1);
		drain();
		write_reg(REG_MAX_ITER, 24'h000001);
		end_writes();
		send_count(16'd0);
		send_count(16'd1);
		drain();

		for (int phase = 0; phase < 8; phase++) begin
			lim = pick_limit();
			write_reg(REG_MAX_ITER, {8'($urandom), lim});
			write_palette(pick_color(), pick_color(), pick_color(), pick_color(),
					pick_color());
			end_writes();
			eff_lim  = (lim == 16'd0) ? 1 : int'(lim);
			calm     = (phase == 7);
			idle_pct = (phase % 3 == 1) ? 0 : ((phase % 3 == 0) ? 25 : 50);
			for (int i = 0; i < 141; i++) begin
				send_count(pick_count(eff_lim));
			end
			drain();
		end

		repeat (20) @(posedge clk);
		if (sb.failures == 0 && sb.pending() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
src/igc_pkg.sv
src/igc_cfg.sv
src/igc_div.sv
src/igc_blend.sv
src/iteration_gradient_colorizer.sv
verif/iteration_gradient_colorizer_tb.sv
